### sv/piecewise_linear_color_map_defines.svh
// assertion macros used by the color map datapath
`ifndef PIECEWISE_LINEAR_COLOR_MAP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLOR_MAP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PLCM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define PLCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/plcm_pkg.sv
// types, constants and codes shared by the color map modules
`timescale 1ns / 1ps

package plcm_pkg;

    localparam int MAX_POINTS    = 16;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int FRACTION_BITS = 16;

    localparam int POS_W     = FRACTION_BITS + 1;
    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 3 * CH_W;
    localparam int NUM_W     = 5;
    localparam int PIDX_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = (SAMPLE_WIDTH > COLOR_W) ? SAMPLE_WIDTH : COLOR_W;
    localparam int DIV_W     = (SAMPLE_WIDTH > POS_W) ? SAMPLE_WIDTH : POS_W;
    localparam int DIV_STEPS = 2;
    localparam int DCNT_W    = $clog2(FRACTION_BITS + 1);
    localparam int PROD_W    = CH_W + POS_W;

    localparam logic [POS_W-1:0] ONE_POS = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef enum logic {
        CMD_CONVERT = 1'b0,
        CMD_LOAD    = 1'b1
    } t_cmd_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALUE_MIN     = 3'd0,
        CFG_VALUE_MAX     = 3'd1,
        CFG_NUM_COLORS    = 3'd2,
        CFG_USE_MASK      = 3'd3,
        CFG_INVALID_COLOR = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        t_cmd_code                 cmd;
        logic [SAMPLE_WIDTH-1:0]   sample;
        logic                      mask_ok;
        logic [PIDX_W-1:0]         point_index;
        logic [POS_W-1:0]          point_position;
        logic [CH_W-1:0]           point_red;
        logic [CH_W-1:0]           point_green;
        logic [CH_W-1:0]           point_blue;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            was_masked;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [COLOR_W-1:0] color;
    } t_point;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_NDIV,
        S_SRCH,
        S_CMP,
        S_RDL,
        S_FRAC,
        S_FDIV,
        S_BLEND
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_point;
        logic norm;
        logic take_pos;
        logic srch_cmp;
        logic rd_right;
        logic rd_left;
        logic frac;
        logic take_frac;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic masked;
        logic norm_div;
        logic div_busy;
        logic srch_more;
        logic frac_div;
        logic out_free;
    } t_dp_stat;

endpackage

### sv/plcm_div.sv
// shared fraction divider, restoring, two quotient bits per cycle
`timescale 1ns / 1ps

module plcm_div import plcm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIV_W-1:0]         i_num,
    input  logic [DIV_W-1:0]         i_den,
    output logic                     o_busy,
    output logic [FRACTION_BITS-1:0] o_quot
);

    logic [DCNT_W-1:0]        r_cnt;
    logic [DCNT_W-1:0]        n_cnt;
    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-1:0]         n_rem;
    logic [DIV_W-1:0]         r_den;
    logic [FRACTION_BITS-1:0] r_quot;
    logic [FRACTION_BITS-1:0] n_quot;
    logic [DIV_W:0]           w_shift;
    logic                     w_qbit;

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

    // remainder stays below the divisor, so the shifted value fits one extra bit
    always_comb begin
        n_rem   = r_rem;
        n_quot  = r_quot;
        w_shift = '0;
        w_qbit  = 1'b0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (DCNT_W'(k) < r_cnt) begin
                w_shift = {n_rem, 1'b0};
                if (w_shift >= {1'b0, r_den}) begin
                    w_shift = w_shift - {1'b0, r_den};
                    w_qbit  = 1'b1;
                end else begin
                    w_qbit  = 1'b0;
                end
                n_rem  = w_shift[DIV_W-1:0];
                n_quot = {n_quot[FRACTION_BITS-2:0], w_qbit};
            end
        end
        if (r_cnt >= DCNT_W'(DIV_STEPS)) begin
            n_cnt = r_cnt - DCNT_W'(DIV_STEPS);
        end else begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(FRACTION_BITS);
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (o_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

endmodule

### sv/plcm_dp.sv
// datapath: config registers, point table, search, divider and blend
`timescale 1ns / 1ps
`include "piecewise_linear_color_map_defines.svh"

module plcm_dp import plcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_item             i_in,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_out_item            o_out
);

    function automatic logic [CH_W-1:0] f_blend(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [POS_W-1:0] f);
        logic [PROD_W-1:0] pa;
        logic [PROD_W-1:0] pb;
        logic [PROD_W:0]   acc;
        pa  = PROD_W'(a) * PROD_W'(ONE_POS - f);
        pb  = PROD_W'(b) * PROD_W'(f);
        acc = {1'b0, pa} + {1'b0, pb};
        return acc[FRACTION_BITS +: CH_W];
    endfunction

    // configuration
    logic [SAMPLE_WIDTH-1:0] r_value_min;
    logic [SAMPLE_WIDTH-1:0] r_value_max;
    logic [NUM_W-1:0]        r_num_colors;
    logic                    r_use_mask;
    logic [COLOR_W-1:0]      r_invalid_color;

    // point table
    t_point                  r_mem [MAX_POINTS];
    t_point                  r_rd;
    logic                    w_mem_we;
    logic [IDX_W-1:0]        w_wr_addr;
    logic [IDX_W-1:0]        w_rd_addr;
    t_point                  w_wr_point;

    // working registers
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic                    r_mask_ok;
    logic                    r_masked;
    logic [POS_W-1:0]        r_pos;
    logic [IDX_W-1:0]        r_lo;
    logic [IDX_W-1:0]        r_hi;
    logic [POS_W-1:0]        r_pr;
    logic [COLOR_W-1:0]      r_cr;
    logic [COLOR_W-1:0]      r_cl;
    logic [POS_W-1:0]        r_frac;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [SAMPLE_WIDTH-1:0] w_ks;
    logic [SAMPLE_WIDTH-1:0] w_kmin;
    logic [SAMPLE_WIDTH-1:0] w_kmax;
    logic                    w_masked;
    logic                    w_norm_zero;
    logic                    w_norm_one;
    logic [IDX_W-1:0]        w_hi_init;
    logic [IDX_W-1:0]        w_mid;
    logic [IDX_W-1:0]        w_right;
    logic [IDX_W-1:0]        w_left;
    logic [POS_W-1:0]        w_pl;
    logic                    w_frac_zero;
    logic                    w_frac_one;
    logic                    w_div_start;
    logic                    w_div_busy;
    logic [DIV_W-1:0]        w_div_num;
    logic [DIV_W-1:0]        w_div_den;
    logic [FRACTION_BITS-1:0] w_quot;
    logic                    w_out_free;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_min     <= '0;
            r_value_max     <= SAMPLE_WIDTH'(1);
            r_num_colors    <= NUM_W'(2);
            r_use_mask      <= 1'b0;
            r_invalid_color <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VALUE_MIN:     r_value_min     <= SAMPLE_WIDTH'(i_cfg_data);
                CFG_VALUE_MAX:     r_value_max     <= SAMPLE_WIDTH'(i_cfg_data);
                CFG_NUM_COLORS:    r_num_colors    <= NUM_W'(i_cfg_data);
                CFG_USE_MASK:      r_use_mask      <= i_cfg_data[0];
                CFG_INVALID_COLOR: r_invalid_color <= COLOR_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------- point table ----------------
    assign w_mem_we   = i_cmd.load_point && (32'(i_in.point_index) < 32'(MAX_POINTS));
    assign w_wr_addr  = IDX_W'(i_in.point_index);
    assign w_wr_point.pos   = (i_in.point_position > ONE_POS) ? ONE_POS : i_in.point_position;
    assign w_wr_point.color = {i_in.point_red, i_in.point_green, i_in.point_blue};

    assign w_mid   = IDX_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    // first bin is used when the search lands on point zero
    assign w_right = (r_lo == '0) ? IDX_W'(1) : r_lo;
    assign w_left  = (r_lo == '0) ? '0 : (r_lo - IDX_W'(1));

    always_comb begin
        priority if (i_cmd.rd_right) begin
            w_rd_addr = w_right;
        end else if (i_cmd.rd_left) begin
            w_rd_addr = w_left;
        end else begin
            w_rd_addr = w_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_wr_point;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // ---------------- normalization ----------------
    // offset binary keeps signed order under unsigned compare
    assign w_ks   = {~r_sample[SAMPLE_WIDTH-1],    r_sample[SAMPLE_WIDTH-2:0]};
    assign w_kmin = {~r_value_min[SAMPLE_WIDTH-1], r_value_min[SAMPLE_WIDTH-2:0]};
    assign w_kmax = {~r_value_max[SAMPLE_WIDTH-1], r_value_max[SAMPLE_WIDTH-2:0]};

    assign w_masked    = r_use_mask && !r_mask_ok;
    assign w_norm_zero = (w_kmax <= w_kmin) || (w_ks <= w_kmin);
    assign w_norm_one  = (w_ks >= w_kmax);

    always_comb begin
        if (r_num_colors < NUM_W'(2)) begin
            w_hi_init = IDX_W'(1);
        end else if (32'(r_num_colors) > 32'(MAX_POINTS)) begin
            w_hi_init = IDX_W'(MAX_POINTS - 1);
        end else begin
            w_hi_init = IDX_W'(r_num_colors - NUM_W'(1));
        end
    end

    // ---------------- bin fraction ----------------
    assign w_pl        = r_rd.pos;
    assign w_frac_zero = (r_pr <= w_pl) || (r_pos <= w_pl);
    assign w_frac_one  = (r_pos >= r_pr);

    // ---------------- shared divider ----------------
    assign w_div_start = (i_cmd.norm && o_stat.norm_div) || (i_cmd.frac && o_stat.frac_div);

    always_comb begin
        if (i_cmd.norm) begin
            w_div_num = DIV_W'(w_ks - w_kmin);
            w_div_den = DIV_W'(w_kmax - w_kmin);
        end else begin
            w_div_num = DIV_W'(r_pos - w_pl);
            w_div_den = DIV_W'(r_pr - w_pl);
        end
    end

    plcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample  <= i_in.sample;
            r_mask_ok <= i_in.mask_ok;
        end
        if (i_cmd.norm) begin
            r_masked <= w_masked;
            r_lo     <= '0;
            r_hi     <= w_hi_init;
            if (w_norm_zero) begin
                r_pos <= '0;
            end else if (w_norm_one) begin
                r_pos <= ONE_POS;
            end
        end
        if (i_cmd.take_pos) begin
            r_pos <= POS_W'(w_quot);
        end
        if (i_cmd.srch_cmp) begin
            if (r_pos > r_rd.pos) begin
                r_lo <= w_mid + IDX_W'(1);
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.rd_left) begin
            r_pr <= r_rd.pos;
            r_cr <= r_rd.color;
        end
        if (i_cmd.frac) begin
            r_cl <= r_rd.color;
            if (w_frac_zero) begin
                r_frac <= '0;
            end else if (w_frac_one) begin
                r_frac <= ONE_POS;
            end
        end
        if (i_cmd.take_frac) begin
            r_frac <= POS_W'(w_quot);
        end
    end

    // ---------------- output register ----------------
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_masked) begin
                r_out.red   <= r_invalid_color[2*CH_W +: CH_W];
                r_out.green <= r_invalid_color[CH_W +: CH_W];
                r_out.blue  <= r_invalid_color[0 +: CH_W];
            end else begin
                r_out.red   <= f_blend(r_cl[2*CH_W +: CH_W], r_cr[2*CH_W +: CH_W], r_frac);
                r_out.green <= f_blend(r_cl[CH_W +: CH_W], r_cr[CH_W +: CH_W], r_frac);
                r_out.blue  <= f_blend(r_cl[0 +: CH_W], r_cr[0 +: CH_W], r_frac);
            end
            r_out.was_masked <= r_masked;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_stat.masked    = w_masked;
    assign o_stat.norm_div  = !w_masked && !w_norm_zero && !w_norm_one;
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.srch_more = (r_lo < r_hi);
    assign o_stat.frac_div  = !w_frac_zero && !w_frac_one;
    assign o_stat.out_free  = w_out_free;

    `PLCM_ASSERT_IMPL(a_div_start_idle, w_div_start, !w_div_busy, "divider restarted while busy")
    `PLCM_ASSERT_IMPL(a_out_load_free, i_cmd.out_load, w_out_free, "result overwrote a pending beat")
    `PLCM_ASSERT_NEXT(a_search_bounds, i_cmd.srch_cmp, r_lo <= r_hi, "search bounds crossed")
    `PLCM_ASSERT_IMPL(a_frac_range, i_cmd.out_load && !r_masked, r_frac <= ONE_POS, "fraction above one")

endmodule

### sv/plcm_ctrl.sv
// controller state machine sequencing one beat through the datapath
`timescale 1ns / 1ps

module plcm_ctrl import plcm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_cmd_code i_in_cmd,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    if (i_in_cmd == CMD_LOAD) begin
                        o_cmd.load_point = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_NORM;
                    end
                end
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                priority if (i_stat.masked) begin
                    n_state = S_BLEND;
                end else if (i_stat.norm_div) begin
                    n_state = S_NDIV;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_NDIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.take_pos = 1'b1;
                    n_state        = S_SRCH;
                end
            end
            S_SRCH: begin
                // table read at the midpoint is in flight
                if (i_stat.srch_more) begin
                    n_state = S_CMP;
                end else begin
                    o_cmd.rd_right = 1'b1;
                    n_state        = S_RDL;
                end
            end
            S_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = S_SRCH;
            end
            S_RDL: begin
                o_cmd.rd_left = 1'b1;
                n_state       = S_FRAC;
            end
            S_FRAC: begin
                o_cmd.frac = 1'b1;
                if (i_stat.frac_div) begin
                    n_state = S_FDIV;
                end else begin
                    n_state = S_BLEND;
                end
            end
            S_FDIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.take_frac = 1'b1;
                    n_state         = S_BLEND;
                end
            end
            S_BLEND: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/piecewise_linear_color_map.sv
// Piecewise-linear color map: turns signed samples into RGB through a table of up to
// 16 control points. A load beat (cmd 1) writes one point and gives no result; table
// slots read before they are written return garbage, so load every slot below
// num_colors first. A convert beat (cmd 0) normalizes the sample against
// value_min/value_max, binary-searches the table and blends the two neighboring colors,
// giving one result beat; a masked beat skips the search and gives the invalid color.
// Otherwise up to two runs of the shared two-bit-per-cycle divider and a search of up to
// four steps, each through S_SRCH and S_CMP on the single-read-port point table, set
// how long a convert takes. The next beat is taken as soon as the previous one reaches
// the output register, even if that result has not been taken yet. Write the
// configuration registers only while the block is idle.
`timescale 1ns / 1ps

module piecewise_linear_color_map import plcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    plcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    plcm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

### tb/tb_top.sv
// self-checking testbench for the piecewise-linear color map
`timescale 1ns / 1ps

module tb_top;
    import plcm_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_beat = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_beat;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_VALUE_MIN;
    logic [CFG_W-1:0] cfg_data = '0;

    // mirror of the block's registers and point table
    logic [SAMPLE_WIDTH-1:0] range_lo = 32'd0;
    logic [SAMPLE_WIDTH-1:0] range_hi = 32'd1;
    logic [NUM_W-1:0] point_count = 5'd2;
    logic mask_en = 1'b0;
    logic [COLOR_W-1:0] masked_color = '0;
    logic [POS_W-1:0] point_pos [MAX_POINTS];
    logic [COLOR_W-1:0] point_rgb [MAX_POINTS];

    t_out_item pending_colors [$];

    int in_idle_pct = 22;
    int out_idle_pct = 68;
    logic hold_req = 1'b0;
    int hold_left = 0;
    logic hold_seen = 1'b0;
    int cycle_count = 0;
    int n_errors = 0;
    int n_checked = 0;
    int n_convert = 0;
    int n_load = 0;
    int n_masked = 0;
    int n_cfg = 0;

    piecewise_linear_color_map dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d colors outstanding",
                     cycle_count, pending_colors.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------- color predictor ----------------

    // offset binary keeps signed order under unsigned compare
    function automatic logic [SAMPLE_WIDTH-1:0] to_key(logic [SAMPLE_WIDTH-1:0] v);
        return {~v[SAMPLE_WIDTH-1], v[SAMPLE_WIDTH-2:0]};
    endfunction

    // restoring division giving FRACTION_BITS quotient bits, num < den
    function automatic logic [POS_W-1:0] div_frac(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [POS_W-1:0] q;
        rem = num;
        q = '0;
        for (int i = 0; i < FRACTION_BITS; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                                    logic [POS_W-1:0] f);
        logic [31:0] acc;
        acc = 32'(a) * (32'(ONE_POS) - 32'(f)) + 32'(b) * 32'(f);
        return acc[FRACTION_BITS +: CH_W];
    endfunction

    function automatic t_out_item map_sample(t_in_item it);
        logic [SAMPLE_WIDTH-1:0] ks, kmin, kmax;
        logic [POS_W-1:0] pos, pl, ph, f;
        logic [COLOR_W-1:0] cl, cr;
        int n, lo, hi, mid, left, right;
        t_out_item r;
        if (mask_en && !it.mask_ok) begin
            r.red = masked_color[23:16];
            r.green = masked_color[15:8];
            r.blue = masked_color[7:0];
            r.was_masked = 1'b1;
            return r;
        end
        ks = to_key(it.sample);
        kmin = to_key(range_lo);
        kmax = to_key(range_hi);
        if (kmax <= kmin || ks <= kmin)
            pos = '0;
        else if (ks >= kmax)
            pos = ONE_POS;
        else
            pos = div_frac(64'(ks - kmin), 64'(kmax - kmin));

        n = 32'(point_count);
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (pos > point_pos[mid])
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo == 0) begin
            left = 0;
            right = 1;
        end else begin
            left = lo - 1;
            right = lo;
        end

        pl = point_pos[left];
        ph = point_pos[right];
        if (ph <= pl || pos <= pl)
            f = '0;
        else if (pos >= ph)
            f = ONE_POS;
        else
            f = div_frac(64'(pos - pl), 64'(ph - pl));

        cl = point_rgb[left];
        cr = point_rgb[right];
        r.red = mix_channel(cl[23:16], cr[23:16], f);
        r.green = mix_channel(cl[15:8], cr[15:8], f);
        r.blue = mix_channel(cl[7:0], cr[7:0], f);
        r.was_masked = 1'b0;
        return r;
    endfunction

    // ---------------- item builders ----------------

    function automatic t_in_item noise_item();
        t_in_item it;
        it.cmd = CMD_CONVERT;
        it.sample = $urandom;
        it.mask_ok = 1'($urandom_range(1));
        it.point_index = 4'($urandom_range(15));
        it.point_position = 17'($urandom_range(17'h1FFFF));
        it.point_red = 8'($urandom_range(255));
        it.point_green = 8'($urandom_range(255));
        it.point_blue = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic t_in_item make_convert(logic [31:0] s, logic ok);
        t_in_item it;
        it = noise_item();
        it.cmd = CMD_CONVERT;
        it.sample = s;
        it.mask_ok = ok;
        return it;
    endfunction

    function automatic t_in_item make_load(int idx, int pos, int r, int g, int b);
        t_in_item it;
        it = noise_item();
        it.cmd = CMD_LOAD;
        it.point_index = 4'(idx);
        it.point_position = 17'(pos);
        it.point_red = 8'(r);
        it.point_green = 8'(g);
        it.point_blue = 8'(b);
        return it;
    endfunction

    // mostly inside the configured range, some anywhere, some right at its ends
    function automatic logic [31:0] pick_sample();
        logic [31:0] kmin, kmax, key;
        logic [63:0] span, r64;
        int sel;
        sel = $urandom_range(99);
        kmin = to_key(range_lo);
        kmax = to_key(range_hi);
        if (sel < 70 && kmax > kmin) begin
            span = 64'(kmax) - 64'(kmin) + 64'd1;
            r64 = 64'($urandom);
            key = 32'(64'(kmin) + r64 % span);
            return to_key(key);
        end
        if (sel < 85)
            return $urandom;
        case ($urandom_range(7))
            0: return range_lo - 32'd1;
            1: return range_lo;
            2: return range_lo + 32'd1;
            3: return range_hi - 32'd1;
            4: return range_hi;
            5: return range_hi + 32'd1;
            6: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // ---------------- drivers ----------------

    task automatic send_item(t_in_item it);
        logic [POS_W-1:0] p;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (it.cmd == CMD_LOAD) begin
            p = (it.point_position > ONE_POS) ? ONE_POS : it.point_position;
            point_pos[it.point_index] = p;
            point_rgb[it.point_index] = {it.point_red, it.point_green, it.point_blue};
            n_load++;
        end else begin
            pending_colors.insert(pending_colors.size(), map_sample(it));
            n_convert++;
            if (mask_en && !it.mask_ok) n_masked++;
        end
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VALUE_MIN: range_lo = val;
            CFG_VALUE_MAX: range_hi = val;
            CFG_NUM_COLORS: point_count = val[NUM_W-1:0];
            CFG_USE_MASK: mask_en = val[0];
            CFG_INVALID_COLOR: masked_color = val[COLOR_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    // drop valid, let every expected color come back, then let a load finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_colors.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_sorted_points();
        int p [$];
        repeat (MAX_POINTS) p.insert(p.size(), $urandom_range(ONE_POS));
        p.sort();
        foreach (p[i])
            send_item(make_load(i, p[i], $urandom_range(255), $urandom_range(255),
                                $urandom_range(255)));
    endtask

    // ---------------- result checking ----------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
                 want);
        n_errors++;
    endtask

    task automatic check_color(t_out_item got);
        t_out_item want;
        if (pending_colors.size() == 0) begin
            report_mismatch("unexpected result beat", 32'(got), 32'd0);
            return;
        end
        want = pending_colors.pop_front();
        n_checked++;
        if (got.red !== want.red) report_mismatch("red", 32'(got.red), 32'(want.red));
        if (got.green !== want.green)
            report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue) report_mismatch("blue", 32'(got.blue), 32'(want.blue));
        if (got.was_masked !== want.was_masked)
            report_mismatch("was_masked", 32'(got.was_masked), 32'(want.was_masked));
    endtask

    // receiver: checks accepted beats, stalls at random or for one long hold
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) check_color(out_beat);
            if (hold_req && !hold_seen) hold_left = HOLD_CYCLES;
            hold_seen = hold_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // ---------------- tests ----------------

    task automatic test_reset_values();
        load_sorted_points();
        // reset range is 0..1, so only the two end positions occur
        send_item(make_convert(-32'sd5, 1'b1));
        send_item(make_convert(32'd0, 1'b0));
        send_item(make_convert(32'd1, 1'b1));
        send_item(make_convert(32'd2, 1'b0));
    endtask

    task automatic test_range_edges();
        wait_idle();
        write_reg(CFG_VALUE_MIN, -32'sd1000);
        write_reg(CFG_VALUE_MAX, 32'd1000);
        write_reg(CFG_NUM_COLORS, 32'd4);
        write_reg(CFG_USE_MASK, 32'd1);
        write_reg(CFG_INVALID_COLOR, 32'hA5C33C);
        send_item(make_load(0, 17'h01000, 255, 0, 255));
        send_item(make_load(1, 17'h08000, 0, 255, 0));
        // zero-width bin between slots 1 and 2
        send_item(make_load(2, 17'h08000, 255, 255, 255));
        send_item(make_load(3, 17'h0C000, 0, 0, 0));
        send_item(make_convert(32'h8000_0000, 1'b1));
        send_item(make_convert(-32'sd1000, 1'b1));
        send_item(make_convert(32'd1000, 1'b1));
        send_item(make_convert(32'h7FFF_FFFF, 1'b1));
        send_item(make_convert(32'd0, 1'b1));
        send_item(make_convert(32'd1, 1'b1));
        send_item(make_convert(32'd500, 1'b0));
        // position past one saturates when stored
        send_item(make_load(3, 17'h1FFFF, 17, 34, 51));
        send_item(make_convert(32'd999, 1'b1));
    endtask

    task automatic test_unsorted_points();
        wait_idle();
        write_reg(CFG_VALUE_MIN, 32'd0);
        write_reg(CFG_VALUE_MAX, 32'h10000);
        send_item(make_load(0, 17'h0F000, 10, 20, 30));
        send_item(make_load(1, 17'h0A000, 200, 100, 50));
        send_item(make_load(2, 17'h05000, 0, 255, 128));
        send_item(make_load(3, 17'h00000, 255, 0, 64));
        send_item(make_convert(32'h6000, 1'b1));
        send_item(make_convert(32'hB000, 1'b1));
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(CFG_VALUE_MIN, -32'sd100);
        write_reg(CFG_VALUE_MAX, 32'd100);
        write_reg(CFG_NUM_COLORS, 32'd0);
        send_item(make_convert(32'd50, 1'b1));
        wait_idle();
        write_reg(CFG_NUM_COLORS, 32'd1);
        send_item(make_convert(32'd0, 1'b1));
        wait_idle();
        write_reg(CFG_NUM_COLORS, 32'd31);
        send_item(make_convert(32'd99, 1'b1));
        wait_idle();
        // empty and inverted ranges put every sample at position zero
        write_reg(CFG_VALUE_MIN, 32'd7);
        write_reg(CFG_VALUE_MAX, 32'd7);
        send_item(make_convert(32'h7FFF_FFFF, 1'b1));
        wait_idle();
        write_reg(CFG_VALUE_MIN, 32'd100);
        write_reg(CFG_VALUE_MAX, -32'sd100);
        send_item(make_convert(32'd0, 1'b1));
        wait_idle();
        write_reg(CFG_VALUE_MIN, 32'h8000_0000);
        write_reg(CFG_VALUE_MAX, 32'h7FFF_FFFF);
        write_reg(CFG_NUM_COLORS, 32'd16);
        write_reg(CFG_USE_MASK, 32'd0);
        write_reg(CFG_INVALID_COLOR, 32'hFFFFFF);
        send_item(make_convert(32'd0, 1'b0));
        send_item(make_convert(32'h8000_0000, 1'b1));
        send_item(make_convert(32'h7FFF_FFFF, 1'b1));
        wait_idle();
        write_reg(CFG_USE_MASK, 32'd1);
        send_item(make_convert($urandom, 1'b0));
    endtask

    // receiver holds off while the sender keeps pushing converts
    task automatic test_output_hold();
        wait_idle();
        in_idle_pct = 0;
        out_idle_pct <= 0;
        hold_req <= 1'b1;
        repeat (16) send_item(make_convert(pick_sample(), 1'($urandom_range(1))));
        wait_idle();
        hold_req <= 1'b0;
    endtask

    task automatic test_random_mix(int send_idle, int recv_idle);
        logic [31:0] span, kmin, mn, mx;
        int sel;
        in_idle_pct = send_idle;
        out_idle_pct <= recv_idle;
        repeat (5) begin
            wait_idle();
            sel = $urandom_range(99);
            if (sel < 55) begin
                span = $urandom_range(200000, 1);
                kmin = $urandom_range(32'hFFFF_FFFF - span, 0);
                mn = to_key(kmin);
                mx = to_key(kmin + span);
            end else if (sel < 70) begin
                mn = 32'h8000_0000;
                mx = 32'h7FFF_FFFF;
            end else if (sel < 85) begin
                mn = $urandom;
                mx = $urandom;
            end else begin
                mn = $urandom;
                mx = (sel < 93) ? mn : mn - $urandom_range(1000, 1);
            end
            write_reg(CFG_VALUE_MIN, mn);
            write_reg(CFG_VALUE_MAX, mx);
            write_reg(CFG_NUM_COLORS, ($urandom_range(99) < 80) ? $urandom_range(16, 2)
                                                                : $urandom_range(31));
            write_reg(CFG_USE_MASK, $urandom_range(1));
            write_reg(CFG_INVALID_COLOR, $urandom);
            load_sorted_points();
            repeat (34) begin
                if ($urandom_range(99) < 85)
                    send_item(make_convert(pick_sample(), ($urandom_range(99) < 80)));
                else
                    send_item(make_load($urandom_range(15),
                                        ($urandom_range(99) < 80)
                                            ? $urandom_range(ONE_POS)
                                            : $urandom_range(17'h1FFFF, ONE_POS + 1),
                                        $urandom_range(255), $urandom_range(255),
                                        $urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_range_edges();
        test_unsorted_points();
        test_register_extremes();
        test_random_mix(22, 68);
        test_output_hold();
        test_random_mix(68, 22);
        test_random_mix(0, 0);
        wait_idle();
        $display("%0d converts (%0d masked) and %0d point loads sent, %0d colors checked",
                 n_convert, n_masked, n_load, n_checked);
        $display("%0d register writes incl. empty/inverted ranges and point counts 0..31",
                 n_cfg);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/plcm_pkg.sv
sv/plcm_div.sv
sv/plcm_dp.sv
sv/plcm_ctrl.sv
sv/piecewise_linear_color_map.sv
tb/tb_top.sv
